/* src/lbbr_pkg.sv */
package lbbr_pkg;

  // Width of one input character.
  localparam int unsigned CHAR_W = 8;

  // Character code of an open bracket; every other code closes.
  localparam logic [CHAR_W-1:0] OPEN_CODE = 8'd40;

endpackage

/* src/longest_balanced_bracket_run.sv */
// Longest balanced bracket run. Stream in one character per word on the slave side, where '('
// opens and any other byte closes, and mark the final character of each string with tlast. One
// result word follows each string: the length of its longest balanced substring, how many end
// positions reach that length (0 and 1 when there is none), and a flag for strings longer than
// MAX_LEN characters, in which case length and count read 0. The block takes one word every
// clock cycle unless stalled, and needs no clearing pass after reset. The result of a string
// appears on the master side in the cycle after its last word is taken. The slave side stalls
// only while a result is held unread and the master side is not ready. The open-bracket stack
// lives in a RAM of MAX_LEN entries with one write port and one registered read port. The top two
// entries are kept in flops, and the read port prefetches the third, so that one push or one pop
// fits in every cycle. All per-string state returns to reset after each last word.
module longest_balanced_bracket_run #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic clk,
  input  logic rst,

  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lbbr_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_code
  input  logic                       s_tlast,   // last_char

  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // m_tdata from bit 0 up: max_length, run_count, too_long, zero fill
  output logic [((($clog2(MAX_LEN + 1) + $clog2(MAX_LEN / 2 + 1) + 1) + 7) / 8) * 8 - 1:0]
                                                       m_tdata
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_LEN / 2 + 1);
  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned RES_W = LEN_W + CNT_W + 1;
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MAX_LEN);

  // Per-string state
  logic [LEN_W-1:0] position, position_next;
  logic [LEN_W-1:0] depth, depth_next;
  logic [AW-1:0]    run_start, run_start_next;
  logic             prev_matched, prev_matched_next;
  logic [LEN_W-1:0] best_length, best_length_next;
  logic [CNT_W-1:0] best_count, best_count_next;
  logic             overflowed, overflowed_next;

  // Stack: top two entries in flops, the rest in RAM
  logic [AW-1:0] mem [MAX_LEN];
  logic [AW-1:0] top, top_next;
  logic [AW-1:0] sec, sec_next;
  logic          sec_from_mem;
  logic [AW-1:0] rd_data;
  logic [AW-1:0] sec_value;
  logic [LEN_W-1:0] rd_full;

  // Result register
  logic [LEN_W-1:0] out_length;
  logic [CNT_W-1:0] out_count;
  logic             out_too_long;

  logic             accept;
  logic             is_open;
  logic             do_push;
  logic             do_pop;
  logic [AW-1:0]    push_value;
  logic [LEN_W-1:0] run_len;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_open  = (s_tdata == lbbr_pkg::OPEN_CODE);
  assign m_tdata  = OUT_W'({out_too_long, out_count, out_length});

  // Second entry is either held in flops or just fetched after a pop.
  assign sec_value  = sec_from_mem ? rd_data : sec;
  assign push_value = prev_matched ? run_start : position[AW-1:0];
  assign run_len    = position - LEN_W'(top) + LEN_W'(1);
  assign rd_full    = depth - LEN_W'(3);

  always_comb begin
    position_next     = position;
    depth_next        = depth;
    run_start_next    = run_start;
    prev_matched_next = prev_matched;
    best_length_next  = best_length;
    best_count_next   = best_count;
    overflowed_next   = overflowed;
    do_push           = 1'b0;
    do_pop            = 1'b0;
    if (accept) begin
      if (position >= LIMIT) begin
        // Drop characters past the limit, remember the overrun.
        overflowed_next = 1'b1;
      end else begin
        position_next = position + LEN_W'(1);
        if (is_open) begin
          if (depth < LIMIT) begin
            do_push    = 1'b1;
            depth_next = depth + LEN_W'(1);
          end
          prev_matched_next = 1'b0;
        end else if (depth == '0) begin
          // Unmatched close: the next open bracket starts afresh.
          prev_matched_next = 1'b0;
        end else begin
          do_pop            = 1'b1;
          depth_next        = depth - LEN_W'(1);
          run_start_next    = top;
          prev_matched_next = 1'b1;
          if (run_len > best_length) begin
            best_length_next = run_len;
            best_count_next  = CNT_W'(1);
          end else if (run_len == best_length) begin
            best_count_next = best_count + CNT_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    top_next = top;
    sec_next = sec_value;
    if (do_push) begin
      top_next = push_value;
      sec_next = top;
    end else if (do_pop) begin
      top_next = sec_value;
    end
  end

  // Stack RAM: write the pushed entry, prefetch the entry below the second.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[depth[AW-1:0]] <= push_value;
    end
    rd_data <= mem[rd_full[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    sec <= sec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      depth        <= '0;
      run_start    <= '0;
      prev_matched <= 1'b0;
      best_length  <= '0;
      best_count   <= '0;
      overflowed   <= 1'b0;
      sec_from_mem <= 1'b0;
    end else if (accept && s_tlast) begin
      // String done: clear for the next one.
      position     <= '0;
      depth        <= '0;
      run_start    <= '0;
      prev_matched <= 1'b0;
      best_length  <= '0;
      best_count   <= '0;
      overflowed   <= 1'b0;
      sec_from_mem <= 1'b0;
    end else begin
      position     <= position_next;
      depth        <= depth_next;
      run_start    <= run_start_next;
      prev_matched <= prev_matched_next;
      best_length  <= best_length_next;
      best_count   <= best_count_next;
      overflowed   <= overflowed_next;
      sec_from_mem <= do_pop;
    end
  end

  // Result word: load on the last character, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      if (overflowed_next) begin
        out_length   <= '0;
        out_count    <= '0;
        out_too_long <= 1'b1;
      end else if (best_length_next == '0) begin
        out_length   <= '0;
        out_count    <= CNT_W'(1);
        out_too_long <= 1'b0;
      end else begin
        out_length   <= best_length_next;
        out_count    <= best_count_next;
        out_too_long <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // An overrun result carries no length or count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_too_long |-> out_length == '0 && out_count == '0)
    else $error("overrun result carries a length or count");

  // An empty result that is not an overrun always reports a count of one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_too_long && out_length == '0 |-> out_count == CNT_W'(1))
    else $error("empty result with count other than one");

  // The stack never holds more entries than characters taken.
  assert property (@(posedge clk) disable iff (rst)
    depth <= position)
    else $error("stack deeper than position");

  // Every last word leaves the string state cleared.
  assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> position == '0 && depth == '0 && best_length == '0)
    else $error("state not cleared after last word");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_LEN / 2 + 1);
  localparam int unsigned IDX_W = LEN_W - 1;
  localparam int unsigned RES_W = ((LEN_W + CNT_W + 1 + 7) / 8) * 8;

  // Any code other than the open code closes; use ')' for bracket text.
  localparam logic [lbbr_pkg::CHAR_W-1:0] CLOSE_CODE = 8'd41;

  typedef struct {
    logic [LEN_W-1:0] max_length;
    logic [CNT_W-1:0] run_count;
    logic             too_long;
  } run_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [lbbr_pkg::CHAR_W-1:0] s_tdata = '0;   // [7:0] char_code
  logic             s_tlast = 1'b0;  // last_char
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;         // max_length, run_count, too_long, zero fill

  longest_balanced_bracket_run #(.MAX_LEN(MAX_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Idle rates in percent, changed per phase by the test tasks.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // Long receiver hold-off: a test posts a length, the receiver counts it down.
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  int unsigned failures = 0;
  int unsigned chars_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned results_checked = 0;
  int unsigned over_len_strings = 0;

  run_result_t expected_runs[$];

  // Bracket matcher shadow state.
  logic [LEN_W-1:0] char_pos;
  logic [LEN_W-1:0] open_depth;
  logic [IDX_W-1:0] open_starts [MAX_LEN];
  logic [IDX_W-1:0] joined_start;
  logic             after_match;
  logic [LEN_W-1:0] best_len;
  logic [CNT_W-1:0] best_cnt;
  logic             over_len;

  function automatic void clear_matcher();
    char_pos = '0;
    open_depth = '0;
    joined_start = '0;
    after_match = 1'b0;
    best_len = '0;
    best_cnt = '0;
    over_len = 1'b0;
  endfunction

  // Advance the matcher by one character; on the last one queue the run summary.
  function automatic void match_char(input logic [lbbr_pkg::CHAR_W-1:0] code, input logic last);
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    run_result_t      res;
    if (char_pos >= MAX_LEN) begin
      // Drop characters past the limit but remember the overflow.
      over_len = 1'b1;
    end else begin
      if (code == lbbr_pkg::OPEN_CODE) begin
        // Join the balanced run just closed, otherwise start at this position.
        open_starts[open_depth[IDX_W-1:0]] = after_match ? joined_start : char_pos[IDX_W-1:0];
        open_depth = open_depth + 1'b1;
        after_match = 1'b0;
      end else if (open_depth == 0) begin
        after_match = 1'b0;
      end else begin
        open_depth = open_depth - 1'b1;
        start = open_starts[open_depth[IDX_W-1:0]];
        len = char_pos - {1'b0, start} + 1'b1;
        joined_start = start;
        after_match = 1'b1;
        if (len > best_len) begin
          best_len = len;
          best_cnt = CNT_W'(1);
        end else if (len == best_len) begin
          best_cnt = best_cnt + 1'b1;
        end
      end
      char_pos = char_pos + 1'b1;
    end
    if (last) begin
      if (over_len) begin
        res = '{max_length: '0, run_count: '0, too_long: 1'b1};
        over_len_strings++;
      end else if (best_len == 0) begin
        res = '{max_length: '0, run_count: CNT_W'(1), too_long: 1'b0};
      end else begin
        res = '{max_length: best_len, run_count: best_cnt, too_long: 1'b0};
      end
      expected_runs.insert(expected_runs.size(), res);
      strings_sent++;
      clear_matcher();
    end
  endfunction

  // Receiver: honor a posted hold-off first, else stall at the phase rate.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result word against the oldest expected summary.
  always @(posedge clk) begin : check_results
    run_result_t want;
    run_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.max_length = m_tdata[LEN_W-1:0];
      got.run_count = m_tdata[LEN_W +: CNT_W];
      got.too_long = m_tdata[LEN_W + CNT_W];
      if (expected_runs.size() == 0) begin
        $error("result word with no string pending: %h", m_tdata);
        failures++;
      end else begin
        want = expected_runs.pop_front();
        results_checked++;
        if (got.max_length !== want.max_length) begin
          $error("max_length: expected %0d, got %0d", want.max_length, got.max_length);
          failures++;
        end
        if (got.run_count !== want.run_count) begin
          $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
          failures++;
        end
        if (got.too_long !== want.too_long) begin
          $error("too_long: expected %0d, got %0d", want.too_long, got.too_long);
          failures++;
        end
      end
    end
  end

  // Offer one word at the falling edge, hold it until taken. Enter and leave at a falling edge.
  task automatic send_char(input logic [lbbr_pkg::CHAR_W-1:0] code, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= code;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    match_char(code, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++)
      send_char(text[i], i == text.len() - 1);
  endtask

  task automatic wait_drained();
    while (expected_runs.size() != 0)
      @(negedge clk);
  endtask

  // Mostly bracket text with a skewed open rate and some stray bytes; some pure noise.
  task automatic send_random_string(output int unsigned len);
    int unsigned open_pct;
    bit          noise;
    logic [lbbr_pkg::CHAR_W-1:0] code;
    len = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
    open_pct = $urandom_range(70, 30);
    noise = ($urandom_range(99) < 15);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise || $urandom_range(99) < 8)
        code = lbbr_pkg::CHAR_W'($urandom_range(255));
      else
        code = ($urandom_range(99) < open_pct) ? lbbr_pkg::OPEN_CODE : CLOSE_CODE;
      send_char(code, i == len - 1);
    end
  endtask

  // Bracket shapes: lone open, lone close, nesting, runs joined across an open,
  // close with empty stack, and the byte extremes acting as closes.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_text("(");
    send_text(")");
    send_text("()");
    send_text("()(())");
    send_text(")()())");
    send_text("(()(");
    send_char(lbbr_pkg::OPEN_CODE, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(lbbr_pkg::OPEN_CODE, 1'b0);
    send_char(8'hFF, 1'b1);
    idle_sender();
    wait_drained();
  endtask

  task automatic test_random(input int unsigned items, input int unsigned snd_pct,
                             input int unsigned rcv_pct);
    int unsigned sent;
    int unsigned len;
    send_idle_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    sent = 0;
    while (sent < items) begin
      send_random_string(len);
      sent += len;
    end
    idle_sender();
    wait_drained();
  endtask

  // Hold the receiver off while short strings keep coming, so the held result
  // backs up into the input; then pause until every result is out and send six more strings.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 80;
    for (int i = 0; i < 12; i++)
      send_text((i % 2) ? "()" : "(())");
    idle_sender();
    wait_drained();
    repeat (5) @(negedge clk);
    for (int i = 0; i < 6; i++)
      send_text(")(()");
    idle_sender();
    wait_drained();
  endtask

  // Longest legal string at full nesting depth, then one character too many.
  task automatic test_length_limits();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < MAX_LEN / 2; i++)
      send_char(lbbr_pkg::OPEN_CODE, 1'b0);
    for (int i = 0; i < MAX_LEN / 2; i++)
      send_char(CLOSE_CODE, i == MAX_LEN / 2 - 1);
    for (int i = 0; i < MAX_LEN / 2; i++) begin
      send_char(lbbr_pkg::OPEN_CODE, 1'b0);
      send_char(CLOSE_CODE, 1'b0);
    end
    send_char(CLOSE_CODE, 1'b1);
    idle_sender();
    wait_drained();
  endtask

  initial begin
    int unsigned spin;
    clear_matcher();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(330, 0, 0);
    test_random(330, 59, 0);
    test_random(330, 0, 59);
    test_random(330, 21, 21);
    test_backpressure();
    test_length_limits();
    test_random(150, 0, 0);

    // Let the last results drain, then leave the block idle before reporting.
    spin = 0;
    while (expected_runs.size() != 0 && spin < 10000) begin
      @(negedge clk);
      spin++;
    end
    if (expected_runs.size() != 0) begin
      $error("%0d string results never arrived", expected_runs.size());
      failures++;
    end
    repeat (10) @(negedge clk);

    $display("Sent %0d characters in %0d strings (%0d over length), checked %0d results.",
             chars_sent, strings_sent, over_len_strings, results_checked);
    $display("Phases: directed shapes, four idle/stall mixes, long hold-off, length limits.");
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
src/lbbr_pkg.sv
src/longest_balanced_bracket_run.sv
sim/testbench.sv
